// ----- hw/rtl/epms_pkg.sv -----
// epms_pkg: shared types and constants of the encoder pid motor speed controller
// used by encoder_pid_motor_speed_core and epms_checker; no dependencies

package epms_pkg;

   // field widths
   localparam int unsigned POS_W    = 32;
   localparam int unsigned DELTA_W  = 21;
   localparam int unsigned ERR_W    = 24;
   localparam int unsigned INTEG_W  = 40;
   localparam int unsigned GAIN_W   = 16;
   localparam int unsigned TARGET_W = 21;
   localparam int unsigned DUTY_W   = 10;
   localparam int unsigned SUM_W    = 58;

   // controller constants
   localparam int unsigned DUTY_MAX    = 512;
   localparam int unsigned SPEED_SCALE = 5;
   localparam int unsigned SCALE_W     = 9;

   // configuration port
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      REG_GAIN_P        = 3'd0,
      REG_GAIN_I        = 3'd1,
      REG_GAIN_D        = 3'd2,
      REG_TARGET_COUNTS = 3'd3,
      REG_MOUNTED_RIGHT = 3'd4
   } reg_index_type;

endpackage

// ----- hw/rtl/encoder_pid_motor_speed_core.sv -----
// encoder_pid_motor_speed_core: pipelined pid speed controller fed by encoder counts
// depends on epms_pkg for widths, constants and register indexes

// Each request carries the encoder count of one control tick and yields one response:
// the pwm duty (0..512), the direction flag and the clipped position change. The block
// is a seven-stage pipeline (count difference, mounting sign and clip, speed error,
// integral and derivative, gain products, pid sum, magnitude and clip). It takes one
// request per cycle while req_tready is high. Every stage holds its item while the
// stage after it is full and stalled, so req_tready drops only when the whole pipeline
// is full and rsp_tready is low. Registers, at byte address 4*index: 0 gain_p,
// 1 gain_i, 2 gain_d (signed Q8.8), 3 target_counts (21 bits signed), 4 mounted_right;
// all reset to zero. Write them only while idle; the block does not enforce it.

module encoder_pid_motor_speed_core (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,    // [31:0] encoder_position
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // [9:0] pwm_duty, [30:10] position_delta, [31] zero
   output logic        rsp_tuser,    // [0] forward
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int unsigned NUM_STAGES = 7;
   localparam int unsigned OUT_STAGE  = NUM_STAGES - 1;

   localparam logic signed [epms_pkg::DELTA_W-1:0] DELTA_HI = {1'b0, {(epms_pkg::DELTA_W-1){1'b1}}};
   localparam logic signed [epms_pkg::DELTA_W-1:0] DELTA_LO = {1'b1, {(epms_pkg::DELTA_W-1){1'b0}}};
   localparam logic signed [epms_pkg::ERR_W-1:0]   ERR_HI   = {1'b0, {(epms_pkg::ERR_W-1){1'b1}}};
   localparam logic signed [epms_pkg::ERR_W-1:0]   ERR_LO   = {1'b1, {(epms_pkg::ERR_W-1){1'b0}}};
   localparam logic signed [epms_pkg::INTEG_W-1:0] INTEG_HI = {1'b0, {(epms_pkg::INTEG_W-1){1'b1}}};
   localparam logic signed [epms_pkg::INTEG_W-1:0] INTEG_LO = {1'b1, {(epms_pkg::INTEG_W-1){1'b0}}};
   localparam logic signed [epms_pkg::SCALE_W-1:0] SCALE_S  = epms_pkg::SCALE_W'(epms_pkg::SPEED_SCALE);
   localparam logic [epms_pkg::SUM_W-9:0]          DUTY_MAX_W = (epms_pkg::SUM_W-8)'(epms_pkg::DUTY_MAX);

   // configuration registers
   logic signed [epms_pkg::GAIN_W-1:0]   gain_p_ff, gain_i_ff, gain_d_ff;
   logic signed [epms_pkg::TARGET_W-1:0] target_counts_ff;
   logic                                 mounted_right_ff;
   logic                                 csr_write;
   epms_pkg::reg_index_type              csr_index;

   // controller state
   logic [epms_pkg::POS_W-1:0]           last_position_ff;
   logic signed [epms_pkg::INTEG_W-1:0]  error_integral_ff, error_integral_in;
   logic signed [epms_pkg::ERR_W-1:0]    last_error_ff;

   // pipeline control
   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] ld;

   // stage 0: wrapped count difference
   logic signed [epms_pkg::POS_W-1:0]    s0_diff_ff, s0_diff_in;
   // stage 1: signed, clipped delta
   logic signed [epms_pkg::DELTA_W-1:0]  s1_delta_ff, s1_delta_in;
   logic signed [epms_pkg::POS_W:0]      s1_neg;
   // stage 2: speed error
   logic signed [epms_pkg::DELTA_W-1:0]  s2_delta_ff;
   logic signed [epms_pkg::ERR_W-1:0]    s2_err_ff, s2_err_in;
   logic signed [epms_pkg::DELTA_W+epms_pkg::SCALE_W-1:0] s2_scaled;
   logic signed [epms_pkg::DELTA_W+epms_pkg::SCALE_W:0]   s2_err_wide;
   // stage 3: error, integral, derivative
   logic signed [epms_pkg::DELTA_W-1:0]  s3_delta_ff;
   logic signed [epms_pkg::ERR_W-1:0]    s3_err_ff;
   logic signed [epms_pkg::INTEG_W-1:0]  s3_integ_ff;
   logic signed [epms_pkg::ERR_W:0]      s3_deriv_ff, s3_deriv_in;
   logic signed [epms_pkg::INTEG_W:0]    s3_integ_sum;
   // stage 4: gain products
   logic signed [epms_pkg::DELTA_W-1:0]  s4_delta_ff;
   logic signed [epms_pkg::GAIN_W+epms_pkg::ERR_W-1:0]   s4_prod_p_ff;
   logic signed [epms_pkg::GAIN_W+epms_pkg::INTEG_W-1:0] s4_prod_i_ff;
   logic signed [epms_pkg::GAIN_W+epms_pkg::ERR_W:0]     s4_prod_d_ff;
   // stage 5: pid sum
   logic signed [epms_pkg::DELTA_W-1:0]  s5_delta_ff;
   logic signed [epms_pkg::SUM_W-1:0]    s5_sum_ff, s5_sum_in;
   // stage 6: response register
   logic [epms_pkg::DELTA_W-1:0]         s6_delta_ff;
   logic [epms_pkg::DUTY_W-1:0]          s6_duty_ff, s6_duty_in;
   logic                                 s6_fwd_ff, s6_fwd_in;
   logic [epms_pkg::SUM_W-1:0]           s6_mag;
   logic [epms_pkg::SUM_W-9:0]           s6_mag_int;

   // ---------------------------------------------------------------- config port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = epms_pkg::reg_index_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff        <= '0;
         gain_i_ff        <= '0;
         gain_d_ff        <= '0;
         target_counts_ff <= '0;
         mounted_right_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            epms_pkg::REG_GAIN_P:        gain_p_ff        <= csr_pwdata[epms_pkg::GAIN_W-1:0];
            epms_pkg::REG_GAIN_I:        gain_i_ff        <= csr_pwdata[epms_pkg::GAIN_W-1:0];
            epms_pkg::REG_GAIN_D:        gain_d_ff        <= csr_pwdata[epms_pkg::GAIN_W-1:0];
            epms_pkg::REG_TARGET_COUNTS: target_counts_ff <= csr_pwdata[epms_pkg::TARGET_W-1:0];
            epms_pkg::REG_MOUNTED_RIGHT: mounted_right_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         epms_pkg::REG_GAIN_P:        csr_prdata = epms_pkg::CSR_DATA_W'(gain_p_ff);
         epms_pkg::REG_GAIN_I:        csr_prdata = epms_pkg::CSR_DATA_W'(gain_i_ff);
         epms_pkg::REG_GAIN_D:        csr_prdata = epms_pkg::CSR_DATA_W'(gain_d_ff);
         epms_pkg::REG_TARGET_COUNTS: csr_prdata = epms_pkg::CSR_DATA_W'(target_counts_ff);
         epms_pkg::REG_MOUNTED_RIGHT: csr_prdata = {31'd0, mounted_right_ff};
         default:                     csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- pipeline control
   // a stage loads when it is empty or its content moves on
   always_comb begin
      ld[OUT_STAGE] = !vld_ff[OUT_STAGE] || rsp_tready;
      for (int k = OUT_STAGE - 1; k >= 0; k--) begin
         ld[k] = !vld_ff[k] || ld[k+1];
      end
   end

   assign req_tready = ld[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (ld[0]) begin
            vld_ff[0] <= req_tvalid;
         end
         for (int k = 1; k < NUM_STAGES; k++) begin
            if (ld[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   // ---------------------------------------------------------------- datapath
   assign s0_diff_in = $signed(req_tdata - last_position_ff);

   // negate in 33 bits so the most negative difference clips instead of wrapping
   assign s1_neg = mounted_right_ff ? -(33'(s0_diff_ff)) : 33'(s0_diff_ff);

   always_comb begin
      if (s1_neg > 33'(DELTA_HI)) begin
         s1_delta_in = DELTA_HI;
      end else if (s1_neg < 33'(DELTA_LO)) begin
         s1_delta_in = DELTA_LO;
      end else begin
         s1_delta_in = s1_neg[epms_pkg::DELTA_W-1:0];
      end
   end

   assign s2_scaled   = s1_delta_ff * SCALE_S;
   assign s2_err_wide = (epms_pkg::DELTA_W+epms_pkg::SCALE_W+1)'(target_counts_ff)
                      - (epms_pkg::DELTA_W+epms_pkg::SCALE_W+1)'(s2_scaled);

   always_comb begin
      if (s2_err_wide > (epms_pkg::DELTA_W+epms_pkg::SCALE_W+1)'(ERR_HI)) begin
         s2_err_in = ERR_HI;
      end else if (s2_err_wide < (epms_pkg::DELTA_W+epms_pkg::SCALE_W+1)'(ERR_LO)) begin
         s2_err_in = ERR_LO;
      end else begin
         s2_err_in = s2_err_wide[epms_pkg::ERR_W-1:0];
      end
   end

   assign s3_integ_sum = (epms_pkg::INTEG_W+1)'(error_integral_ff)
                       + (epms_pkg::INTEG_W+1)'(s2_err_ff);
   assign s3_deriv_in  = (epms_pkg::ERR_W+1)'(s2_err_ff) - (epms_pkg::ERR_W+1)'(last_error_ff);

   always_comb begin
      if (s3_integ_sum > (epms_pkg::INTEG_W+1)'(INTEG_HI)) begin
         error_integral_in = INTEG_HI;
      end else if (s3_integ_sum < (epms_pkg::INTEG_W+1)'(INTEG_LO)) begin
         error_integral_in = INTEG_LO;
      end else begin
         error_integral_in = s3_integ_sum[epms_pkg::INTEG_W-1:0];
      end
   end

   assign s5_sum_in = epms_pkg::SUM_W'(s4_prod_p_ff) + epms_pkg::SUM_W'(s4_prod_i_ff)
                    + epms_pkg::SUM_W'(s4_prod_d_ff);

   // magnitude of the q8.8 sum, truncated toward zero and clipped
   assign s6_fwd_in  = !s5_sum_ff[epms_pkg::SUM_W-1];
   assign s6_mag     = s6_fwd_in ? s5_sum_ff : -s5_sum_ff;
   assign s6_mag_int = s6_mag[epms_pkg::SUM_W-1:8];
   assign s6_duty_in = (s6_mag_int > DUTY_MAX_W) ? DUTY_MAX_W[epms_pkg::DUTY_W-1:0]
                                                 : s6_mag_int[epms_pkg::DUTY_W-1:0];

   // state advances with the item that uses it
   always_ff @(posedge clock) begin
      if (reset) begin
         last_position_ff  <= '0;
         error_integral_ff <= '0;
         last_error_ff     <= '0;
      end else begin
         if (req_tvalid && ld[0]) begin
            last_position_ff <= req_tdata;
         end
         if (vld_ff[2] && ld[3]) begin
            error_integral_ff <= error_integral_in;
            last_error_ff     <= s2_err_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         s0_diff_ff <= s0_diff_in;
      end
      if (ld[1]) begin
         s1_delta_ff <= s1_delta_in;
      end
      if (ld[2]) begin
         s2_delta_ff <= s1_delta_ff;
         s2_err_ff   <= s2_err_in;
      end
      if (ld[3]) begin
         s3_delta_ff <= s2_delta_ff;
         s3_err_ff   <= s2_err_ff;
         s3_integ_ff <= error_integral_in;
         s3_deriv_ff <= s3_deriv_in;
      end
      if (ld[4]) begin
         s4_delta_ff  <= s3_delta_ff;
         s4_prod_p_ff <= gain_p_ff * s3_err_ff;
         s4_prod_i_ff <= gain_i_ff * s3_integ_ff;
         s4_prod_d_ff <= gain_d_ff * s3_deriv_ff;
      end
      if (ld[5]) begin
         s5_delta_ff <= s4_delta_ff;
         s5_sum_ff   <= s5_sum_in;
      end
      if (ld[6]) begin
         s6_delta_ff <= s5_delta_ff;
         s6_duty_ff  <= s6_duty_in;
         s6_fwd_ff   <= s6_fwd_in;
      end
   end

   assign rsp_tvalid = vld_ff[OUT_STAGE];
   assign rsp_tdata  = {1'b0, s6_delta_ff, s6_duty_ff};
   assign rsp_tuser  = s6_fwd_ff;

endmodule

// ----- hw/rtl/epms_checker.sv -----
// epms_checker: port-level assertions for encoder_pid_motor_speed_core
// depends on epms_pkg; bound to the top level at the end of this file

module epms_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        csr_pready
);

   // pipeline comes out of reset empty
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // duty never exceeds its clip
   a_duty_clip : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[9:0] <= 10'(epms_pkg::DUTY_MAX)))
      else $error("pwm duty above clip");

   // padding bit stays clear
   a_pad_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[31] == 1'b0))
      else $error("response padding bit set");

   // stalled response holds
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // an empty output stage never blocks requests
   a_no_false_stall : assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && csr_pready |-> req_tready)
      else $error("request stalled while output stage empty");

endmodule

bind encoder_pid_motor_speed_core epms_checker u_epms_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .csr_pready (csr_pready)
);
